FILE: rtl/core/oqke_pkg.sv
// Shared types and codes for the ordered queue with key edit.
// No dependencies; imported by every module of the block.
package oqke_pkg;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_SEARCH  = 3'd1;
    localparam logic [2:0] OP_MODIFY  = 3'd2;
    localparam logic [2:0] OP_DELETE  = 3'd3;
    localparam logic [2:0] OP_DISPLAY = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] key;
        logic signed [31:0] new_value;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic               last;
        logic [4:0]         entries_held;
    } result_t;

    // broadcast commands from control to every cell
    typedef struct packed {
        logic capture;     // latch compare result against request key
        logic write_tail;  // cell just past the last held entry loads write data
        logic write_first; // first matching cell loads write data
        logic shift;       // cells at or after the first match take the neighbor
        logic rotate;      // whole held list rotates one place toward the head
    } cell_cmd_t;

endpackage

FILE: rtl/core/oqke_cell.sv
// One storage cell of the queue chain: holds an entry and its compare hit.
// Depends on oqke_pkg (cell_cmd_t).
module oqke_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 5
) (
    input  logic                  clk,
    input  oqke_pkg::cell_cmd_t   cmd,
    input  logic [CW-1:0]         count,
    input  logic signed [31:0]    cmp_key,
    input  logic signed [31:0]    wdata,
    input  logic signed [31:0]    head,
    input  logic signed [31:0]    nbr,
    input  logic                  first,
    input  logic                  after,
    output logic signed [31:0]    entry,
    output logic                  hit
);
    import oqke_pkg::*;

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               hit_reg;
    logic               hit_next;
    logic               held;
    logic               at_tail;
    logic               last_held;

    assign held      = CW'(INDEX) < count;
    assign at_tail   = CW'(INDEX) == count;
    assign last_held = (CW'(INDEX) + CW'(1)) == count;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.write_tail && at_tail)
        begin
            entry_next = wdata;
        end
        if (cmd.write_first && first)
        begin
            entry_next = wdata;
        end
        if (cmd.shift && after)
        begin
            entry_next = nbr;
        end
        if (cmd.rotate)
        begin
            entry_next = last_held ? head : nbr;
        end
    end

    assign hit_next = cmd.capture ? (held && (entry_reg == cmp_key)) : hit_reg;

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        hit_reg   <= hit_next;
    end

    assign entry = entry_reg;
    assign hit   = hit_reg;

endmodule

FILE: rtl/core/oqke_ctrl.sv
// Sequencer of the queue: request capture, first-match pick, count and results.
// Depends on oqke_pkg (codes, request_t, result_t, cell_cmd_t).
module oqke_ctrl #(
    parameter int DEPTH = 16,
    parameter int CW    = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  oqke_pkg::request_t    request,
    output oqke_pkg::result_t     result,
    output logic                  done,
    input  logic [DEPTH-1:0]      hit,
    input  logic signed [31:0]    head,
    output oqke_pkg::cell_cmd_t   cmd,
    output logic [DEPTH-1:0]      first,
    output logic [DEPTH-1:0]      after,
    output logic [CW-1:0]         count,
    output logic signed [31:0]    wdata
);
    import oqke_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DISP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [IW-1:0]      disp_reg, disp_next;
    logic               done_reg, done_next;
    logic [2:0]         op_reg, op_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] nv_reg, nv_next;
    result_t            result_reg, result_next;
    logic               any_hit;
    logic               disp_last;

    // isolate lowest set hit, then mark it and everything above it
    assign first     = hit & (~hit + DEPTH'(1));
    assign after     = ~(first - DEPTH'(1));
    assign any_hit   = |hit;
    assign disp_last = (CW'(disp_reg) + CW'(1)) == count_reg;
    assign wdata     = (op_reg == OP_INSERT) ? key_reg : nv_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        disp_next   = disp_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        key_next    = key_reg;
        nv_next     = nv_reg;
        result_next = result_reg;
        cmd         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    op_next     = request.op;
                    key_next    = request.key;
                    nv_next     = request.new_value;
                    disp_next   = '0;
                    if (request.op == OP_DISPLAY && count_reg != '0)
                    begin
                        state_next = S_DISP;
                    end
                    else
                    begin
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC:
            begin
                done_next          = 1'b1;
                state_next         = S_IDLE;
                result_next.status = ST_OK;
                if (op_reg == OP_INSERT)
                begin
                    if (count_reg == CW'(DEPTH))
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        cmd.write_tail = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                end
                else if (op_reg > OP_DISPLAY)
                begin
                    result_next.status = ST_OK;
                end
                else if (count_reg == '0)
                begin
                    result_next.status = ST_EMPTY;
                end
                else if (!any_hit)
                begin
                    result_next.status = ST_MISSING;
                end
                else
                begin
                    case (op_reg)
                        OP_MODIFY:
                        begin
                            cmd.write_first = 1'b1;
                        end
                        OP_DELETE:
                        begin
                            cmd.shift  = 1'b1;
                            count_next = count_reg - CW'(1);
                        end
                        default:
                        begin
                            cmd.shift = 1'b0;
                        end
                    endcase
                end
                result_next.element      = '0;
                result_next.last         = 1'b1;
                result_next.entries_held = 5'(count_next);
            end
            S_DISP:
            begin
                // head cell is emitted, chain rotates so the next entry arrives
                done_next                = 1'b1;
                cmd.rotate               = 1'b1;
                result_next.status       = ST_OK;
                result_next.element      = head;
                result_next.last         = disp_last;
                result_next.entries_held = 5'(count_reg);
                disp_next                = disp_reg + IW'(1);
                if (disp_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            disp_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            disp_reg  <= disp_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        nv_reg     <= nv_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;
    assign count  = count_reg;

endmodule

FILE: rtl/core/ordered_queue_with_key_edit.sv
// Top level of the ordered queue with key edit: a chain of entry cells plus sequencer.
// Depends on oqke_pkg, oqke_cell and oqke_ctrl.
//
//  channel   | signals                 | handshake
//  ----------+-------------------------+-------------------------------------
//  request   | start, busy, request    | taken at a clock edge with start && !busy
//  result    | done, result            | done marks each result, no back-pressure
//
// Insert, search, modify, delete, unused ops and display of an empty list: every cell
// latches its compare as the request is taken, then S_EXEC updates the chain and result.
// Display of N held entries: one result per cycle (S_DISP) as the chain rotates.
// busy stays high until the last result is registered; rst_n clears count and control.
// The receiver cannot stall; done marks each result for one cycle only.
module ordered_queue_with_key_edit #(
    parameter int DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  oqke_pkg::request_t  request,
    output oqke_pkg::result_t   result,
    output logic                done
);
    import oqke_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    cell_cmd_t          cmd;
    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   first;
    logic [DEPTH-1:0]   after;
    logic [CW-1:0]      count;
    logic signed [31:0] wdata;
    logic signed [31:0] entry [DEPTH];

    oqke_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .done    (done),
        .hit     (hit),
        .head    (entry[0]),
        .cmd     (cmd),
        .first   (first),
        .after   (after),
        .count   (count),
        .wdata   (wdata)
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] nbr;
        if (i == DEPTH - 1)
        begin : g_end
            assign nbr = entry[i];
        end
        else
        begin : g_mid
            assign nbr = entry[i + 1];
        end

        oqke_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .count   (count),
            .cmp_key (request.key),
            .wdata   (wdata),
            .head    (entry[0]),
            .nbr     (nbr),
            .first   (first[i]),
            .after   (after[i]),
            .entry   (entry[i]),
            .hit     (hit[i])
        );
    end

endmodule

FILE: tb/ordered_queue_with_key_edit_tb.sv
// Self-checking testbench for ordered_queue_with_key_edit: a directed table, then random requests.
// Every result is checked against an in-bench model of the ordered list, or against the row's expected result.
// Depends on oqke_pkg and the ordered_queue_with_key_edit RTL.
`timescale 1ns / 100ps

module ordered_queue_with_key_edit_tb;

    import oqke_pkg::*;

    localparam int         DEPTH        = 16;
    localparam int         RANDOM_ITEMS = 310;
    localparam int         DRAIN_CYCLES = DEPTH + 8;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         MAX_REPORTS  = 10;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct {
        request_t req;
        int       reps;      // repeated with key + n on repeat n
        bit       has_want;
        result_t  want;
    } stim_row_t;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // typed expectation travels with the request it belongs to
    logic     row_has_want = 1'b0;
    result_t  row_want     = '0;

    logic signed [31:0] list_model [DEPTH];
    int                 list_len = 0;
    result_t            pending_results [$];
    stim_row_t          directed_rows [$];
    int                 mismatch_count = 0;
    int                 cycle_count    = 0;
    int                 burst_left     = 0;

    ordered_queue_with_key_edit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .result  (result),
        .done    (done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic result_t single_result(logic [1:0] st, int held);
        result_t r;
        r              = '0;
        r.status       = st;
        r.last         = 1'b1;
        r.entries_held = 5'(held);
        return r;
    endfunction

    function automatic void add_row(logic [2:0] op, logic signed [31:0] key,
                                    logic signed [31:0] nv, int reps, bit has_want,
                                    result_t want);
        stim_row_t row;
        row.req.op        = op;
        row.req.key       = key;
        row.req.new_value = nv;
        row.reps          = reps;
        row.has_want      = has_want;
        row.want          = want;
        directed_rows.push_back(row);
    endfunction

    // Applies one request to the list model and queues the results it causes.
    function automatic void predict_request(request_t req, bit has_want, result_t want);
        result_t r;
        int      pos;
        int      i;
        bit      emitted;
        r       = single_result(ST_OK, 0);
        pos     = -1;
        emitted = 1'b0;
        case (req.op)
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    list_model[list_len] = req.key;
                    list_len++;
                end
            end
            OP_SEARCH, OP_MODIFY, OP_DELETE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < list_len && pos < 0; i++)
                        if (list_model[i] === req.key)
                            pos = i;
                    if (pos < 0)
                        r.status = ST_MISSING;
                    else if (req.op == OP_MODIFY)
                        list_model[pos] = req.new_value;
                    else if (req.op == OP_DELETE)
                    begin
                        for (i = pos; i + 1 < list_len; i++)
                            list_model[i] = list_model[i + 1];
                        list_len--;
                    end
                end
            end
            OP_DISPLAY:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i < list_len; i++)
                    begin
                        r.element = list_model[i];
                        r.last    = (i + 1 == list_len);
                        r.entries_held = 5'(list_len);
                        pending_results.push_back(r);
                    end
                    emitted = 1'b1;
                end
            end
            default: ;  // unused codes leave the list alone
        endcase
        r.entries_held = 5'(list_len);
        if (has_want)
            pending_results.push_back(want);
        else if (!emitted)
            pending_results.push_back(r);
    endfunction

    function automatic void check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("t=%0t unexpected result: status=%0d element=%0d last=%0d held=%0d",
                         $realtime, got.status, got.element, got.last, got.entries_held);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status || got.element !== want.element ||
            got.last !== want.last || got.entries_held !== want.entries_held)
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display({"t=%0t mismatch: expected status=%0d element=%0d last=%0d held=%0d,",
                          " got status=%0d element=%0d last=%0d held=%0d"},
                         $realtime, want.status, want.element, want.last, want.entries_held,
                         got.status, got.element, got.last, got.entries_held);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                predict_request(request, row_has_want, row_want);
            if (done)
                check_result(result);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic signed [31:0] random_word();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 30)
            return $signed(32'($urandom_range(0, 7))) - 32'sd4;
        if (roll < 40)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7FFF_FFFF;
                2:       return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        return $signed($urandom());
    endfunction

    // fill_bias leans toward inserts so the list reaches full, otherwise toward deletes
    function automatic request_t random_request(bit fill_bias);
        request_t req;
        int       roll;
        roll          = $urandom_range(0, 99);
        req.key       = random_word();
        req.new_value = random_word();
        if (roll < 3)
            req.op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else if (roll < 12)
            req.op = OP_DISPLAY;
        else if (roll < (fill_bias ? 60 : 30))
            req.op = OP_INSERT;
        else if (roll < (fill_bias ? 70 : 55))
            req.op = OP_SEARCH;
        else if (roll < (fill_bias ? 80 : 70))
            req.op = OP_MODIFY;
        else
            req.op = OP_DELETE;
        // mostly look for a key that is held so edits actually land
        if (req.op != OP_INSERT && list_len > 0 && $urandom_range(0, 99) < 70)
            req.key = list_model[$urandom_range(0, list_len - 1)];
        return req;
    endfunction

    task automatic send_request(request_t req, bit has_want, result_t want);
        int gap;
        if (burst_left > 0)
        begin
            gap = 0;
            burst_left--;
        end
        else
        begin
            gap = $urandom_range(0, 4);
            if ($urandom_range(0, 29) == 0)
                burst_left = $urandom_range(10, 30);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        request      <= req;
        row_has_want <= has_want;
        row_want     <= want;
        do
            @(posedge clk);
        while (!(start && !busy));
    endtask

    initial
    begin
        request_t req;
        bit       fill_bias;
        int       n;
        int       k;

        // empty list, unused code, sole-entry delete
        add_row(OP_SEARCH,    32'sd0, 32'sd0, 1, 1, single_result(ST_EMPTY, 0));
        add_row(OP_MODIFY,    32'sd0, 32'sd5, 1, 1, single_result(ST_EMPTY, 0));
        add_row(OP_DELETE,    32'sd0, 32'sd0, 1, 1, single_result(ST_EMPTY, 0));
        add_row(OP_DISPLAY,   32'sd0, 32'sd0, 1, 1, single_result(ST_EMPTY, 0));
        add_row(OP_UNUSED_LO, 32'sd0, 32'sd0, 1, 1, single_result(ST_OK, 0));
        add_row(OP_INSERT, 32'sh8000_0000, 32'sd0, 1, 1, single_result(ST_OK, 1));
        add_row(OP_DELETE, 32'sh8000_0000, 32'sd0, 1, 1, single_result(ST_OK, 0));
        add_row(OP_DISPLAY,   32'sd0, 32'sd0, 1, 1, single_result(ST_EMPTY, 0));
        // extremes and a duplicate key
        add_row(OP_INSERT, 32'sh7FFF_FFFF, 32'sd0, 1, 1, single_result(ST_OK, 1));
        add_row(OP_INSERT, 32'sh8000_0000, 32'sd0, 1, 1, single_result(ST_OK, 2));
        add_row(OP_INSERT, -32'sd1,        32'sd0, 1, 1, single_result(ST_OK, 3));
        add_row(OP_INSERT, -32'sd1,        32'sd0, 1, 1, single_result(ST_OK, 4));
        add_row(OP_SEARCH, 32'sh8000_0000, 32'sd0, 1, 1, single_result(ST_OK, 4));
        add_row(OP_SEARCH, 32'sd0,         32'sd0, 1, 1, single_result(ST_MISSING, 4));
        add_row(OP_MODIFY, -32'sd1, 32'sh7FFF_FFFF, 1, 1, single_result(ST_OK, 4));
        add_row(OP_DISPLAY, 32'sd0, 32'sd0, 1, 0, '0);
        add_row(OP_DELETE, 32'sh7FFF_FFFF, 32'sd0, 1, 1, single_result(ST_OK, 3));
        add_row(OP_DELETE, -32'sd1,        32'sd0, 1, 1, single_result(ST_OK, 2));
        add_row(OP_MODIFY, 32'sd12345, 32'sd1, 1, 1, single_result(ST_MISSING, 2));
        add_row(OP_DELETE, 32'sd12345, 32'sd0, 1, 1, single_result(ST_MISSING, 2));
        // fill to the top, overflow, then edit a full list
        add_row(OP_INSERT, 32'sd100, 32'sd0, DEPTH - 2, 0, '0);
        add_row(OP_INSERT, 32'sd42,  32'sd0, 1, 1, single_result(ST_FULL, DEPTH));
        add_row(OP_DISPLAY, 32'sd0, 32'sd0, 1, 0, '0);
        add_row(OP_UNUSED_HI, 32'sd0, 32'sd0, 1, 1, single_result(ST_OK, DEPTH));
        add_row(OP_DELETE, 32'sd107, 32'sd0, 1, 1, single_result(ST_OK, DEPTH - 1));
        add_row(OP_DISPLAY, 32'sd0, 32'sd0, 1, 0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            for (k = 0; k < directed_rows[i].reps; k++)
            begin
                req     = directed_rows[i].req;
                req.key = req.key + k;
                send_request(req, directed_rows[i].has_want, directed_rows[i].want);
            end
        end

        fill_bias = 1'b1;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (list_len >= DEPTH)
                fill_bias = 1'b0;
            else if (list_len == 0)
                fill_bias = 1'b1;
            else if ($urandom_range(0, 49) == 0)
                fill_bias = !fill_bias;
            send_request(random_request(fill_bias), 1'b0, '0);
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
